### src/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared sizes, codes and types of the piece-table text buffer.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // store and table sizes
  localparam int MAX_PIECES = 128;
  localparam int ADD_BYTES  = 1024;
  localparam int ORIG_BYTES = 4096;

  // field widths
  localparam int POS_W   = 13;
  localparam int LEN_W   = 13;
  localparam int CHAR_W  = 8;
  localparam int PCNT_W  = 8;
  localparam int STAT_W  = 2;
  localparam int MODE_W  = 2;

  // derived widths
  localparam int CNT_W   = $clog2(MAX_PIECES + 1);
  localparam int TAB_AW  = $clog2(MAX_PIECES);
  localparam int ORIG_AW = $clog2(ORIG_BYTES);
  localparam int ADD_AW  = $clog2(ADD_BYTES);
  localparam int OFILL_W = $clog2(ORIG_BYTES + 1);
  localparam int AFILL_W = $clog2(ADD_BYTES + 1);

  // modes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STAT_W-1:0] ST_TABLE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_STORE  = 2'd3;

  // piece sources
  localparam logic SRC_ORIG = 1'b0;
  localparam logic SRC_ADD  = 1'b1;

  typedef struct packed {
    logic             src;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
  } piece_t;

  localparam int PIECE_W = 1 + 2 * LEN_W;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  count;
    logic [CHAR_W-1:0] char_in;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  doc_length;
    logic [PCNT_W-1:0] piece_count;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

### src/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ptb_engine.sv
// ----------------------------------------------------------------------------
// ptb_engine
// Sequencer that walks, shifts and compacts the piece table held in RAM and
// fills the original and added byte stores.
// ----------------------------------------------------------------------------
module ptb_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ptb_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output ptb_pkg::result_t res
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_EV  = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_PUT      = 4'd6;
  localparam logic [3:0] S_CMP_RD   = 4'd7;
  localparam logic [3:0] S_CMP_EV   = 4'd8;
  localparam logic [3:0] S_BYTE     = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  localparam int CNT_W = ptb_pkg::CNT_W;
  localparam int POS_W = ptb_pkg::POS_W;
  localparam int LEN_W = ptb_pkg::LEN_W;

  logic [3:0]                     state;
  ptb_pkg::item_t                 op;
  logic [CNT_W-1:0]               used;
  logic [POS_W-1:0]               total;
  logic [ptb_pkg::OFILL_W-1:0]    ofill;
  logic [ptb_pkg::AFILL_W-1:0]    afill;
  logic                           run_active;
  logic [POS_W-1:0]               run_pos;
  logic [ptb_pkg::AFILL_W-1:0]    run_start;
  logic [ptb_pkg::STAT_W-1:0]     status;
  logic [ptb_pkg::CHAR_W-1:0]     cout;
  logic [CNT_W-1:0]               i;
  logic [CNT_W-1:0]               k;
  logic [CNT_W-1:0]               wn;
  logic [CNT_W-1:0]               gap_at;
  logic [CNT_W-1:0]               base;
  logic [1:0]                     gap;
  logic [POS_W:0]                 cs;
  logic [POS_W-1:0]               sum;
  logic [POS_W-1:0]               fin_total;
  ptb_pkg::piece_t                np;
  ptb_pkg::piece_t                lst [3];
  logic [1:0]                     lst_n;
  logic [1:0]                     j;
  logic                           byte_src;
  logic                           byte_oob;

  // memory ports
  logic                           tab_we;
  logic [ptb_pkg::TAB_AW-1:0]     tab_waddr;
  ptb_pkg::piece_t                tab_wdata;
  logic [ptb_pkg::TAB_AW-1:0]     tab_raddr;
  logic [ptb_pkg::PIECE_W-1:0]    tab_q;
  logic                           orig_we;
  logic                           add_we;
  logic [ptb_pkg::CHAR_W-1:0]     orig_q;
  logic [ptb_pkg::CHAR_W-1:0]     add_q;

  // per-entry evaluation
  ptb_pkg::piece_t                p;
  ptb_pkg::piece_t                head;
  ptb_pkg::piece_t                tail;
  logic [POS_W:0]                 ce;
  logic [POS_W:0]                 pos14;
  logic [POS_W:0]                 ipos14;
  logic [POS_W:0]                 pe;
  logic [POS_W:0]                 skip;
  logic [LEN_W-1:0]               off;
  logic [POS_W:0]                 byte_idx;
  logic                           ins_hit;
  logic                           rd_hit;
  logic                           overlap;
  logic                           cut_head;
  logic                           cut_tail;
  logic [ptb_pkg::OFILL_W-1:0]    ofill_after;
  logic [ptb_pkg::AFILL_W-1:0]    afill_after;
  logic [ptb_pkg::AFILL_W-1:0]    rstart;
  logic [POS_W-1:0]               ins_p;
  logic [CNT_W:0]                 sh_addr;
  logic [CNT_W:0]                 put_addr;
  logic                           orig_full;
  logic                           add_full;

  assign p        = ptb_pkg::piece_t'(tab_q);
  assign pos14    = {1'b0, op.position};
  assign ipos14   = {1'b0, run_pos};
  assign pe       = pos14 + {1'b0, op.count};
  assign ce       = cs + {1'b0, p.len};
  assign off      = LEN_W'(ipos14 - cs);
  assign ins_hit  = (ipos14 >= cs) && (ipos14 <= ce);
  assign rd_hit   = pos14 < ce;
  assign overlap  = !((pe <= cs) || (pos14 >= ce));
  assign cut_head = overlap && (pos14 > cs);
  assign cut_tail = overlap && (pe < ce);
  assign skip     = (pe > cs) ? (pe - cs) : '0;
  assign byte_idx = {1'b0, p.start} + (pos14 - cs);

  // trimmed halves of the current piece
  always_comb begin
    head       = p;
    head.len   = LEN_W'(pos14 - cs);
    tail       = p;
    tail.start = p.start + LEN_W'(skip);
    tail.len   = p.len - LEN_W'(skip);
  end

  // fill pointers after this byte
  assign orig_full   = ofill >= ptb_pkg::OFILL_W'(ptb_pkg::ORIG_BYTES);
  assign add_full    = afill >= ptb_pkg::AFILL_W'(ptb_pkg::ADD_BYTES);
  assign ofill_after = orig_full ? ofill : ofill + 1'b1;
  assign afill_after = add_full ? afill : afill + 1'b1;
  assign rstart      = run_active ? run_start : afill;
  assign ins_p       = run_active ? run_pos : op.position;
  assign sh_addr     = {1'b0, k} - 1'b1 + {{(CNT_W - 1){1'b0}}, gap};
  assign put_addr    = {1'b0, base} + {{(CNT_W - 1){1'b0}}, j};

  // table RAM ports
  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = '0;
    tab_wdata = p;
    tab_raddr = ptb_pkg::TAB_AW'(i);
    case (state)
      S_EXEC: begin
        if (op.mode == ptb_pkg::MODE_LOAD && op.last) begin
          tab_we    = 1'b1;
          tab_wdata = '{src: ptb_pkg::SRC_ORIG, start: '0, len: LEN_W'(ofill_after)};
        end
      end
      S_SHIFT_RD: tab_raddr = ptb_pkg::TAB_AW'(k - 1'b1);
      S_SHIFT_WR: begin
        tab_we    = 1'b1;
        tab_waddr = ptb_pkg::TAB_AW'(sh_addr);
      end
      S_PUT: begin
        tab_we    = 1'b1;
        tab_waddr = ptb_pkg::TAB_AW'(put_addr);
        tab_wdata = lst[j];
      end
      S_CMP_EV: begin
        tab_waddr = ptb_pkg::TAB_AW'(wn);
        if (!overlap) begin
          tab_we = 1'b1;
        end else if (cut_head) begin
          tab_we    = 1'b1;
          tab_wdata = head;
        end else if (cut_tail) begin
          tab_we    = 1'b1;
          tab_wdata = tail;
        end
      end
      default: tab_we = 1'b0;
    endcase
  end

  assign orig_we = (state == S_EXEC) && (op.mode == ptb_pkg::MODE_LOAD) && !orig_full;
  assign add_we  = (state == S_EXEC) && (op.mode == ptb_pkg::MODE_INSERT) && !add_full;

  ptb_ram #(.WIDTH(ptb_pkg::PIECE_W), .DEPTH(ptb_pkg::MAX_PIECES)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_q)
  );

  ptb_ram #(.WIDTH(ptb_pkg::CHAR_W), .DEPTH(ptb_pkg::ORIG_BYTES)) u_orig (
    .clk   (clk),
    .we    (orig_we),
    .waddr (ofill[ptb_pkg::ORIG_AW-1:0]),
    .wdata (op.char_in),
    .raddr (byte_idx[ptb_pkg::ORIG_AW-1:0]),
    .rdata (orig_q)
  );

  ptb_ram #(.WIDTH(ptb_pkg::CHAR_W), .DEPTH(ptb_pkg::ADD_BYTES)) u_add (
    .clk   (clk),
    .we    (add_we),
    .waddr (afill[ptb_pkg::ADD_AW-1:0]),
    .wdata (op.char_in),
    .raddr (byte_idx[ptb_pkg::ADD_AW-1:0]),
    .rdata (add_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      total      <= '0;
      ofill      <= '0;
      afill      <= '0;
      run_active <= 1'b0;
      run_pos    <= '0;
      run_start  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= item;
            status <= ptb_pkg::ST_OK;
            cout   <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          i  <= '0;
          cs <= '0;
          unique case (op.mode)
            ptb_pkg::MODE_LOAD: begin
              ofill <= ofill_after;
              if (orig_full) begin
                status <= ptb_pkg::ST_STORE;
              end
              if (op.last) begin
                used       <= CNT_W'(1);
                total      <= POS_W'(ofill_after);
                ofill      <= '0;
                afill      <= '0;
                run_active <= 1'b0;
              end
              state <= S_DONE;
            end
            ptb_pkg::MODE_INSERT: begin
              run_pos   <= ins_p;
              run_start <= rstart;
              afill     <= afill_after;
              if (add_full) begin
                status <= ptb_pkg::ST_STORE;
              end
              state <= S_DONE;
              if (!op.last) begin
                run_active <= 1'b1;
              end else begin
                run_active <= 1'b0;
                if (afill_after > rstart) begin
                  np <= '{src: ptb_pkg::SRC_ADD, start: LEN_W'(rstart),
                          len: LEN_W'(afill_after - rstart)};
                  if (ins_p > total) begin
                    status <= ptb_pkg::ST_BOUNDS;
                    afill  <= rstart;
                  end else begin
                    state <= S_SCAN_RD;
                  end
                end
              end
            end
            ptb_pkg::MODE_READ: state <= S_SCAN_RD;
            ptb_pkg::MODE_DELETE: begin
              state <= (op.count == '0) ? S_DONE : S_SCAN_RD;
            end
            default: state <= S_DONE;
          endcase
        end
        S_SCAN_RD: begin
          if (i != used) begin
            state <= S_SCAN_EV;
          end else begin
            // end of table reached
            state <= S_DONE;
            if (op.mode == ptb_pkg::MODE_INSERT) begin
              gap_at    <= used;
              base      <= used;
              gap       <= 2'd1;
              lst[0]    <= np;
              lst_n     <= 2'd1;
              k         <= used;
              fin_total <= total + np.len;
              if ({1'b0, used} + 1'b1 > (CNT_W + 1)'(ptb_pkg::MAX_PIECES)) begin
                status <= ptb_pkg::ST_TABLE;
                afill  <= run_start;
              end else begin
                state <= S_SHIFT_RD;
              end
            end else if (op.mode == ptb_pkg::MODE_DELETE) begin
              i     <= '0;
              cs    <= '0;
              wn    <= '0;
              sum   <= '0;
              state <= S_CMP_RD;
            end
          end
        end
        S_SCAN_EV: begin
          cs    <= ce;
          i     <= i + 1'b1;
          state <= S_SCAN_RD;
          if (op.mode == ptb_pkg::MODE_INSERT && ins_hit) begin
            // new piece lands before, after or inside this piece
            k         <= used;
            fin_total <= total + np.len;
            if (off == '0) begin
              gap_at <= i;
              base   <= i;
              gap    <= 2'd1;
              lst[0] <= np;
              lst_n  <= 2'd1;
            end else if (off == p.len) begin
              gap_at <= i + 1'b1;
              base   <= i + 1'b1;
              gap    <= 2'd1;
              lst[0] <= np;
              lst_n  <= 2'd1;
            end else begin
              gap_at <= i + 1'b1;
              base   <= i;
              gap    <= 2'd2;
              lst[0] <= '{src: p.src, start: p.start, len: off};
              lst[1] <= np;
              lst[2] <= '{src: p.src, start: p.start + off, len: p.len - off};
              lst_n  <= 2'd3;
            end
            if ({1'b0, used} + ((off == '0 || off == p.len) ? 2'd1 : 2'd2) >
                (CNT_W + 1)'(ptb_pkg::MAX_PIECES)) begin
              status <= ptb_pkg::ST_TABLE;
              afill  <= run_start;
              state  <= S_DONE;
            end else begin
              state <= S_SHIFT_RD;
            end
          end else if (op.mode == ptb_pkg::MODE_READ && rd_hit) begin
            byte_src <= p.src;
            byte_oob <= (p.src == ptb_pkg::SRC_ORIG) ?
                        (byte_idx >= (POS_W + 1)'(ptb_pkg::ORIG_BYTES)) :
                        (byte_idx >= (POS_W + 1)'(ptb_pkg::ADD_BYTES));
            state    <= S_BYTE;
          end else if (op.mode == ptb_pkg::MODE_DELETE && cut_head && cut_tail) begin
            // range lies strictly inside one piece: split it
            gap_at    <= i + 1'b1;
            base      <= i;
            gap       <= 2'd1;
            lst[0]    <= head;
            lst[1]    <= tail;
            lst_n     <= 2'd2;
            k         <= used;
            fin_total <= total - op.count;
            if ({1'b0, used} + 1'b1 > (CNT_W + 1)'(ptb_pkg::MAX_PIECES)) begin
              status <= ptb_pkg::ST_TABLE;
              state  <= S_DONE;
            end else begin
              state <= S_SHIFT_RD;
            end
          end
        end
        S_SHIFT_RD: begin
          if (k == gap_at) begin
            j     <= '0;
            state <= S_PUT;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          k     <= k - 1'b1;
          state <= S_SHIFT_RD;
        end
        S_PUT: begin
          if (j == lst_n - 1'b1) begin
            used  <= used + {{(CNT_W - 2){1'b0}}, gap};
            total <= fin_total;
            state <= S_DONE;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_CMP_RD: begin
          if (i == used) begin
            used  <= wn;
            total <= sum;
            state <= S_DONE;
          end else begin
            state <= S_CMP_EV;
          end
        end
        S_CMP_EV: begin
          if (tab_we) begin
            wn  <= wn + 1'b1;
            sum <= sum + tab_wdata.len;
          end
          cs    <= ce;
          i     <= i + 1'b1;
          state <= S_CMP_RD;
        end
        S_BYTE: begin
          if (byte_oob) begin
            cout <= '0;
          end else begin
            cout <= (byte_src == ptb_pkg::SRC_ADD) ? add_q : orig_q;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = state == S_IDLE;
  assign res_valid       = state == S_DONE;
  assign res.char_out    = cout;
  assign res.doc_length  = total;
  assign res.piece_count = ptb_pkg::PCNT_W'(used);
  assign res.status      = status;

  // table never grows past its depth
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(ptb_pkg::MAX_PIECES))
    else $error("piece count beyond table depth");

  // store fill pointers stay within their stores
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (ofill <= ptb_pkg::OFILL_W'(ptb_pkg::ORIG_BYTES)) &&
    (afill <= ptb_pkg::AFILL_W'(ptb_pkg::ADD_BYTES)))
    else $error("store fill pointer out of range");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted word did not start");

  // a shift write never lands below the gap
  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_WR) |-> (k > gap_at))
    else $error("shift write below gap");

endmodule

### src/piece_table_text_buffer.sv
// ----------------------------------------------------------------------------
// piece_table_text_buffer
// Piece-table text store with load, insert, read and delete over a stream port.
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word. A load or insert byte that
// is not the last of its run goes only through the execute and done states.
// Reads, inserts on last and deletes walk the piece table held in a
// single-port-read RAM one entry at a time, with a read and an evaluate state
// per entry: a read stops at the piece holding the position, an insert walks
// to its position, moves later pieces up and writes up to 3 entries, and a
// delete walks the table for a split and, if none, again to compact it. A new
// word is taken as soon as the previous result sits in the output register.
module piece_table_text_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[12:0], count[25:13], char_in[33:26]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // char_out[7:0], doc_length[20:8],
                                     // piece_count[28:21], status[30:29]
);

  ptb_pkg::item_t   item;
  ptb_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;

  // unpack input word
  assign item.mode     = s_axis_tuser;
  assign item.position = s_axis_tdata[12:0];
  assign item.count    = s_axis_tdata[25:13];
  assign item.char_in  = s_axis_tdata[33:26];
  assign item.last     = s_axis_tlast;

  ptb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {1'b0, res.status, res.piece_count, res.doc_length, res.char_out};
    end
  end

endmodule
